// ===== rtl/edte_pkg.sv =====
// shared types, constants and lookup tables for the e-mail date parser
// no dependencies
package edte_pkg;

    localparam int P_MAX_LEN    = 128;
    localparam int P_ZONE_CHARS = 8;
    localparam int ZONE_COUNT   = 43;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_string;
    } t_in_beat;

    typedef struct packed {
        logic               parse_status;
        logic signed [63:0] epoch_seconds;
        logic               zone_named;
        logic [5:0]         zone_entry;
    } t_out_beat;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } t_num_phase;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_BASE,
        STEP_LEAP,
        STEP_HOUR,
        STEP_MIN,
        STEP_SEC,
        STEP_DONE
    } t_calc_step;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FINISH,
        ST_BASE,
        ST_LEAP,
        ST_HOUR,
        ST_MIN,
        ST_SEC,
        ST_DONE
    } t_ctrl_state;

    typedef struct packed {
        logic       take_byte;
        logic       finish;
        logic       clear;
        t_calc_step step;
    } t_dp_cmd;

    // names padded with '.', only len characters compared
    typedef struct packed {
        logic [31:0] name;
        logic [2:0]  len;
        logic [4:0]  hours;
        logic        west;
    } t_zone;

    localparam t_zone ZONE_TABLE [ZONE_COUNT] = '{
        '{"aat.", 3'd3, 5'd1, 1'b1},  '{"adt.", 3'd3, 5'd4, 1'b0},
        '{"ast.", 3'd3, 5'd3, 1'b0},  '{"bst.", 3'd3, 5'd1, 1'b0},
        '{"cat.", 3'd3, 5'd1, 1'b0},  '{"cdt.", 3'd3, 5'd5, 1'b1},
        '{"cest", 3'd4, 5'd2, 1'b0},  '{"cet.", 3'd3, 5'd1, 1'b0},
        '{"cst.", 3'd3, 5'd6, 1'b1},  '{"eat.", 3'd3, 5'd3, 1'b0},
        '{"edt.", 3'd3, 5'd4, 1'b1},  '{"eest", 3'd4, 5'd3, 1'b0},
        '{"eet.", 3'd3, 5'd2, 1'b0},  '{"egst", 3'd4, 5'd0, 1'b0},
        '{"egt.", 3'd3, 5'd1, 1'b1},  '{"est.", 3'd3, 5'd5, 1'b1},
        '{"gmt.", 3'd3, 5'd0, 1'b0},  '{"gst.", 3'd3, 5'd4, 1'b0},
        '{"hkt.", 3'd3, 5'd8, 1'b0},  '{"ict.", 3'd3, 5'd7, 1'b0},
        '{"idt.", 3'd3, 5'd3, 1'b0},  '{"ist.", 3'd3, 5'd2, 1'b0},
        '{"jst.", 3'd3, 5'd9, 1'b0},  '{"kst.", 3'd3, 5'd9, 1'b0},
        '{"mdt.", 3'd3, 5'd6, 1'b1},  '{"met.", 3'd3, 5'd1, 1'b0},
        '{"msd.", 3'd3, 5'd4, 1'b0},  '{"msk.", 3'd3, 5'd3, 1'b0},
        '{"mst.", 3'd3, 5'd7, 1'b1},  '{"nzdt", 3'd4, 5'd13, 1'b0},
        '{"nzst", 3'd4, 5'd12, 1'b0}, '{"pdt.", 3'd3, 5'd7, 1'b1},
        '{"pst.", 3'd3, 5'd8, 1'b1},  '{"sat.", 3'd3, 5'd2, 1'b0},
        '{"smt.", 3'd3, 5'd4, 1'b0},  '{"sst.", 3'd3, 5'd11, 1'b1},
        '{"utc.", 3'd3, 5'd0, 1'b0},  '{"wat.", 3'd3, 5'd0, 1'b0},
        '{"west", 3'd4, 5'd1, 1'b0},  '{"wet.", 3'd3, 5'd0, 1'b0},
        '{"wgst", 3'd4, 5'd2, 1'b1},  '{"wgt.", 3'd3, 5'd3, 1'b1},
        '{"wst.", 3'd3, 5'd8, 1'b0}
    };

    function automatic logic [23:0] month_abbr(input logic [3:0] idx);
        case (idx)
            4'd0:    month_abbr = "jan";
            4'd1:    month_abbr = "feb";
            4'd2:    month_abbr = "mar";
            4'd3:    month_abbr = "apr";
            4'd4:    month_abbr = "may";
            4'd5:    month_abbr = "jun";
            4'd6:    month_abbr = "jul";
            4'd7:    month_abbr = "aug";
            4'd8:    month_abbr = "sep";
            4'd9:    month_abbr = "oct";
            4'd10:   month_abbr = "nov";
            4'd11:   month_abbr = "dec";
            default: month_abbr = 24'h0;
        endcase
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] idx);
        case (idx)
            4'd0:    month_start = 9'd0;
            4'd1:    month_start = 9'd31;
            4'd2:    month_start = 9'd59;
            4'd3:    month_start = 9'd90;
            4'd4:    month_start = 9'd120;
            4'd5:    month_start = 9'd151;
            4'd6:    month_start = 9'd181;
            4'd7:    month_start = 9'd212;
            4'd8:    month_start = 9'd243;
            4'd9:    month_start = 9'd273;
            4'd10:   month_start = 9'd304;
            4'd11:   month_start = 9'd334;
            default: month_start = 9'd0;
        endcase
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== rtl/edte_ctrl.sv =====
// controller for the date parser: input and output handshakes, step sequencing
// depends on edte_pkg
module edte_ctrl
    import edte_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_ctrl_state r_state, n_state;
    logic        r_out_full, n_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

    assign o_out_valid = r_out_full;

    always_comb begin
        n_state     = r_state;
        n_out_full  = r_out_full && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '{take_byte: 1'b0, finish: 1'b0, clear: 1'b0, step: STEP_NONE};
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_byte = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_BASE;
            end
            ST_BASE: begin
                o_cmd.step = STEP_BASE;
                n_state    = ST_LEAP;
            end
            ST_LEAP: begin
                o_cmd.step = STEP_LEAP;
                n_state    = ST_HOUR;
            end
            ST_HOUR: begin
                o_cmd.step = STEP_HOUR;
                n_state    = ST_MIN;
            end
            ST_MIN: begin
                o_cmd.step = STEP_MIN;
                n_state    = ST_SEC;
            end
            ST_SEC: begin
                o_cmd.step = STEP_SEC;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // wait while the previous result beat is still held
                if (!r_out_full || i_out_ready) begin
                    o_cmd.step  = STEP_DONE;
                    o_cmd.clear = 1'b1;
                    n_out_full  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/edte_datapath.sv =====
// datapath for the date parser: per-byte token scanner, field store, epoch arithmetic
// depends on edte_pkg
module edte_datapath
    import edte_pkg::*;
#(
    parameter int MAX_LEN    = P_MAX_LEN,
    parameter int ZONE_CHARS = P_ZONE_CHARS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_beat  i_in_beat,
    output t_out_beat o_out_beat
);

    localparam int CNTW = $clog2(MAX_LEN);
    localparam int ZLW  = $clog2(ZONE_CHARS + 2);

    logic [CNTW-1:0]    r_byte_cnt, n_byte_cnt;
    logic               r_ended, n_ended;
    logic               r_comma, n_comma;
    logic [2:0]         r_tok, n_tok;
    logic               r_in_tok, n_in_tok;
    logic               r_err, n_err;
    logic [31:0]        r_acc, n_acc;
    t_num_phase         r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [4:0]         r_day, n_day;
    logic [3:0]         r_mon, n_mon;
    logic [31:0]        r_yrs, n_yrs;
    logic [31:0]        r_clk [3];
    logic [31:0]        n_clk [3];
    logic [1:0]         r_cidx, n_cidx;
    logic [1:0]         r_cdone, n_cdone;
    logic [7:0]         r_ztxt [ZONE_CHARS];
    logic [ZLW-1:0]     r_zlen, n_zlen;
    logic               r_zcom, n_zcom;
    logic               r_zlead, n_zlead;
    logic               r_zclosed, n_zclosed;
    logic signed [19:0] r_zoff, n_zoff;
    logic               r_met, n_met;
    logic               r_znamed, n_znamed;
    logic [5:0]         r_zentry, n_zentry;
    logic signed [63:0] r_g, n_g;
    t_out_beat          r_out, n_out;

    // end of token results
    logic [2:0]         et_tok;
    logic               et_err;
    logic [4:0]         et_day;
    logic [3:0]         et_mon;
    logic [31:0]        et_yrs;
    logic [31:0]        et_clk [3];
    logic signed [19:0] et_zoff;
    logic               et_met;
    logic               et_znamed;
    logic [5:0]         et_zentry;

    logic               wnv_ok;
    logic [1:0]         et_done;
    logic               mon_hit;
    logic [3:0]         mon_idx;
    logic               zn_hit;
    logic [5:0]         zn_idx;
    logic               len3, len4;
    logic [6:0]         zh, zm;
    logic [19:0]        zabs;

    // byte scanner
    logic [7:0]         c, lc;
    logic               start;
    logic               whole;
    logic               skip;
    logic [31:0]        cur_acc;
    t_num_phase         cur_phase;
    logic [1:0]         cur_cidx;
    logic [1:0]         cur_cdone;
    logic [ZLW-1:0]     cur_zlen;
    logic               cur_zcom, cur_zlead, cur_zclosed;
    logic [35:0]        prod;
    logic               txt_we;
    logic               do_end, do_clear_parse;

    // arithmetic
    logic signed [33:0] yr70, yr69, q;
    logic signed [43:0] ydays;
    logic signed [10:0] g0;

    assign c  = i_in_beat.text_byte;
    assign lc = to_lower(c);

    assign len3 = (r_zlen == ZLW'(3));
    assign len4 = (r_zlen == ZLW'(4));

    always_comb begin
        et_tok    = (r_tok < 3'd7) ? r_tok + 3'd1 : r_tok;
        et_err    = r_err;
        et_day    = r_day;
        et_mon    = r_mon;
        et_yrs    = r_yrs;
        et_clk    = r_clk;
        et_zoff   = r_zoff;
        et_met    = r_met;
        et_znamed = r_znamed;
        et_zentry = r_zentry;
        et_done   = r_cdone;
        wnv_ok    = (r_phase == PH_DIGITS) && !(r_neg && r_acc != 32'd0) && !r_acc[31];
        mon_hit   = 1'b0;
        mon_idx   = 4'd0;
        zn_hit    = 1'b0;
        zn_idx    = 6'd0;
        zh        = 7'd0;
        zm        = 7'd0;
        zabs      = 20'd0;
        for (int i = 11; i >= 0; i--) begin
            if (r_zlen >= ZLW'(3) && {r_ztxt[0], r_ztxt[1], r_ztxt[2]} == month_abbr(4'(i))) begin
                mon_hit = 1'b1;
                mon_idx = 4'(i);
            end
        end
        for (int i = ZONE_COUNT - 1; i >= 0; i--) begin
            if (((ZONE_TABLE[i].len == 3'd3 && len3) ||
                 (ZONE_TABLE[i].len == 3'd4 && len4 && r_ztxt[3] == ZONE_TABLE[i].name[7:0]))
                && r_ztxt[0] == ZONE_TABLE[i].name[31:24]
                && r_ztxt[1] == ZONE_TABLE[i].name[23:16]
                && r_ztxt[2] == ZONE_TABLE[i].name[15:8]) begin
                zn_hit = 1'b1;
                zn_idx = 6'(i);
            end
        end
        case (r_tok)
            3'd0: begin
                if (wnv_ok && r_acc <= 32'd31) begin
                    et_day = r_acc[4:0];
                end else begin
                    et_err = 1'b1;
                end
            end
            3'd1: begin
                et_err = !mon_hit;
                if (mon_hit) begin
                    et_mon = mon_idx;
                end
            end
            3'd2: begin
                if (wnv_ok) begin
                    if (r_acc < 32'd50) begin
                        et_yrs = r_acc + 32'd100;
                    end else if (r_acc >= 32'd1900) begin
                        et_yrs = r_acc - 32'd1900;
                    end else begin
                        et_yrs = r_acc;
                    end
                end else begin
                    et_err = 1'b1;
                end
            end
            3'd3: begin
                if (r_phase == PH_DIGITS) begin
                    et_clk[r_cidx] = r_neg ? 32'd0 - r_acc : r_acc;
                    et_done        = r_cdone + 2'd1;
                end
                if (et_done < 2'd2) begin
                    et_err = 1'b1;
                end else if (et_done == 2'd2) begin
                    et_clk[2] = 32'd0;
                end
            end
            3'd4: begin
                et_zoff = 20'sd0;
                if (r_zlen >= ZLW'(1) && (r_ztxt[0] == CH_PLUS || r_ztxt[0] == CH_MINUS)) begin
                    if (r_zlen >= ZLW'(5) && is_digit(r_ztxt[1]) && is_digit(r_ztxt[2])
                        && is_digit(r_ztxt[3]) && is_digit(r_ztxt[4])) begin
                        zh   = 7'(r_ztxt[1] - CH_ZERO) * 7'd10 + 7'(r_ztxt[2] - CH_ZERO);
                        zm   = 7'(r_ztxt[3] - CH_ZERO) * 7'd10 + 7'(r_ztxt[4] - CH_ZERO);
                        zabs = 20'(zh) * 20'd3600 + 20'(zm) * 20'd60;
                        et_zoff = (r_ztxt[0] == CH_PLUS) ? -$signed(zabs) : $signed(zabs);
                    end
                end else begin
                    if (zn_hit) begin
                        zabs      = 20'(ZONE_TABLE[zn_idx].hours) * 20'd3600;
                        et_zoff   = ZONE_TABLE[zn_idx].west ? $signed(zabs) : -$signed(zabs);
                        et_znamed = 1'b1;
                        et_zentry = zn_idx;
                    end
                    if (!r_zcom && len3 && r_ztxt[0] == "m" && r_ztxt[1] == "e"
                        && r_ztxt[2] == "t") begin
                        et_met = 1'b1;
                    end
                end
            end
            3'd5: begin
                if (r_met && len3 && r_ztxt[0] == "d" && r_ztxt[1] == "s" && r_ztxt[2] == "t") begin
                    et_zoff = r_zoff - 20'sd3600;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_byte_cnt = r_byte_cnt;
        n_ended    = r_ended;
        n_comma    = r_comma;
        n_tok      = r_tok;
        n_in_tok   = r_in_tok;
        n_err      = r_err;
        n_acc      = r_acc;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_day      = r_day;
        n_mon      = r_mon;
        n_yrs      = r_yrs;
        n_clk      = r_clk;
        n_cidx     = r_cidx;
        n_cdone    = r_cdone;
        n_zlen     = r_zlen;
        n_zcom     = r_zcom;
        n_zlead    = r_zlead;
        n_zclosed  = r_zclosed;
        n_zoff     = r_zoff;
        n_met      = r_met;
        n_znamed   = r_znamed;
        n_zentry   = r_zentry;
        n_g        = r_g;
        n_out      = r_out;

        start       = !r_in_tok;
        whole       = (r_tok != 3'd3);
        skip        = 1'b0;
        cur_acc     = start ? 32'd0 : r_acc;
        cur_phase   = start ? PH_START : r_phase;
        cur_cidx    = start ? 2'd0 : r_cidx;
        cur_cdone   = start ? 2'd0 : r_cdone;
        cur_zlen    = start ? '0 : r_zlen;
        cur_zcom    = start ? 1'b0 : r_zcom;
        cur_zlead   = start ? 1'b0 : r_zlead;
        cur_zclosed = start ? 1'b0 : r_zclosed;
        prod        = ({4'd0, cur_acc} << 3) + ({4'd0, cur_acc} << 1) + 36'(c - CH_ZERO);
        txt_we      = 1'b0;
        do_end      = 1'b0;
        do_clear_parse = 1'b0;

        yr70  = $signed({2'b00, r_yrs}) - 34'sd70;
        yr69  = $signed({2'b00, r_yrs}) - 34'sd69;
        q     = yr69[33] ? (yr69 + 34'sd3) >>> 2 : yr69 >>> 2;
        ydays = yr70 * 44'sd365;
        g0    = $signed({2'b00, month_start(r_mon)}) + $signed({6'd0, r_day})
              - (((r_yrs[1:0] != 2'd0) || (r_mon < 4'd2)) ? 11'sd1 : 11'sd0);

        if (i_cmd.take_byte && !r_ended && r_byte_cnt < CNTW'(MAX_LEN - 1)) begin
            n_byte_cnt = r_byte_cnt + 1'b1;
            if (c == CH_NUL) begin
                n_ended = 1'b1;
            end else if (c == CH_COMMA && !r_comma) begin
                n_comma        = 1'b1;
                do_clear_parse = 1'b1;
            end else if (c == CH_SPACE || c == CH_TAB) begin
                do_end = r_in_tok;
            end else if (!r_in_tok && r_tok == 3'd0 && (c == CH_CR || c == CH_LF)) begin
                n_in_tok = r_in_tok;
            end else begin
                n_in_tok  = 1'b1;
                n_acc     = cur_acc;
                n_phase   = cur_phase;
                n_neg     = start ? 1'b0 : r_neg;
                n_cidx    = cur_cidx;
                n_cdone   = cur_cdone;
                n_zlen    = cur_zlen;
                n_zcom    = cur_zcom;
                n_zlead   = cur_zlead;
                n_zclosed = cur_zclosed;
                case (r_tok)
                    3'd0, 3'd2, 3'd3: begin
                        if (cur_phase != PH_STOP) begin
                            if (is_digit(c)) begin
                                n_acc   = (whole && prod[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                          : prod[31:0];
                                n_phase = PH_DIGITS;
                            end else if (cur_phase == PH_START && c >= CH_LF && c <= CH_CR) begin
                                n_phase = cur_phase;
                            end else if (cur_phase == PH_START
                                         && (c == CH_PLUS || c == CH_MINUS)) begin
                                n_neg   = (c == CH_MINUS);
                                n_phase = PH_SIGN;
                            end else if (!whole && cur_phase == PH_DIGITS && c == CH_COLON
                                         && cur_cidx < 2'd2) begin
                                n_clk[cur_cidx] = n_neg ? 32'd0 - cur_acc : cur_acc;
                                n_cdone = cur_cdone + 2'd1;
                                n_cidx  = cur_cidx + 2'd1;
                                n_phase = PH_START;
                                n_neg   = 1'b0;
                                n_acc   = 32'd0;
                            end else begin
                                if (!whole && cur_phase == PH_DIGITS) begin
                                    n_clk[cur_cidx] = n_neg ? 32'd0 - cur_acc : cur_acc;
                                    n_cdone = cur_cdone + 2'd1;
                                end
                                n_phase = PH_STOP;
                            end
                        end
                    end
                    3'd1, 3'd4, 3'd5: begin
                        if (!cur_zclosed) begin
                            if (r_tok == 3'd4 && start && c == CH_LPAREN) begin
                                n_zcom  = 1'b1;
                                n_zlead = 1'b1;
                            end else begin
                                if (cur_zcom) begin
                                    if (c == CH_RPAREN) begin
                                        n_zclosed = 1'b1;
                                        skip      = 1'b1;
                                    end else if (cur_zlead && (c == CH_CR || c == CH_LF)) begin
                                        skip = 1'b1;
                                    end else begin
                                        n_zlead = 1'b0;
                                    end
                                end
                                if (!skip) begin
                                    txt_we = (cur_zlen < ZLW'(ZONE_CHARS));
                                    if (cur_zlen <= ZLW'(ZONE_CHARS)) begin
                                        n_zlen = cur_zlen + 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (i_cmd.finish) begin
            do_end = r_in_tok;
        end

        if (do_end) begin
            n_tok     = et_tok;
            n_in_tok  = 1'b0;
            n_err     = et_err;
            n_day     = et_day;
            n_mon     = et_mon;
            n_yrs     = et_yrs;
            n_clk     = et_clk;
            n_zoff    = et_zoff;
            n_met     = et_met;
            n_znamed  = et_znamed;
            n_zentry  = et_zentry;
        end

        case (i_cmd.step)
            STEP_BASE: n_g = 64'(g0) + 64'(ydays);
            STEP_LEAP: n_g = r_g + 64'(q);
            STEP_HOUR: n_g = (r_g <<< 4) + (r_g <<< 3) + 64'($signed(r_clk[0]));
            STEP_MIN:  n_g = (r_g <<< 6) - (r_g <<< 2) + 64'($signed(r_clk[1]));
            STEP_SEC:  n_g = (r_g <<< 6) - (r_g <<< 2) + 64'($signed(r_clk[2]));
            STEP_DONE: begin
                if (r_err || r_tok < 3'd4) begin
                    n_out = '{parse_status: 1'b1, epoch_seconds: -64'sd1,
                              zone_named: 1'b0, zone_entry: 6'd0};
                end else begin
                    n_out = '{parse_status: 1'b0, epoch_seconds: r_g + 64'(r_zoff),
                              zone_named: r_znamed,
                              zone_entry: r_znamed ? r_zentry : 6'd0};
                end
            end
            default: n_g = r_g;
        endcase

        if (i_cmd.clear) begin
            n_byte_cnt     = '0;
            n_ended        = 1'b0;
            n_comma        = 1'b0;
            do_clear_parse = 1'b1;
        end

        if (do_clear_parse) begin
            n_tok     = 3'd0;
            n_in_tok  = 1'b0;
            n_err     = 1'b0;
            n_acc     = 32'd0;
            n_phase   = PH_START;
            n_neg     = 1'b0;
            n_day     = 5'd0;
            n_mon     = 4'd0;
            n_yrs     = 32'd0;
            n_clk     = '{32'd0, 32'd0, 32'd0};
            n_cidx    = 2'd0;
            n_cdone   = 2'd0;
            n_zlen    = '0;
            n_zcom    = 1'b0;
            n_zlead   = 1'b0;
            n_zclosed = 1'b0;
            n_zoff    = 20'sd0;
            n_met     = 1'b0;
            n_znamed  = 1'b0;
            n_zentry  = 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_ended    <= 1'b0;
            r_comma    <= 1'b0;
            r_tok      <= 3'd0;
            r_in_tok   <= 1'b0;
            r_err      <= 1'b0;
            r_acc      <= 32'd0;
            r_phase    <= PH_START;
            r_neg      <= 1'b0;
            r_day      <= 5'd0;
            r_mon      <= 4'd0;
            r_yrs      <= 32'd0;
            r_clk      <= '{32'd0, 32'd0, 32'd0};
            r_cidx     <= 2'd0;
            r_cdone    <= 2'd0;
            r_zlen     <= '0;
            r_zcom     <= 1'b0;
            r_zlead    <= 1'b0;
            r_zclosed  <= 1'b0;
            r_zoff     <= 20'sd0;
            r_met      <= 1'b0;
            r_znamed   <= 1'b0;
            r_zentry   <= 6'd0;
        end else begin
            r_byte_cnt <= n_byte_cnt;
            r_ended    <= n_ended;
            r_comma    <= n_comma;
            r_tok      <= n_tok;
            r_in_tok   <= n_in_tok;
            r_err      <= n_err;
            r_acc      <= n_acc;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_day      <= n_day;
            r_mon      <= n_mon;
            r_yrs      <= n_yrs;
            r_clk      <= n_clk;
            r_cidx     <= n_cidx;
            r_cdone    <= n_cdone;
            r_zlen     <= n_zlen;
            r_zcom     <= n_zcom;
            r_zlead    <= n_zlead;
            r_zclosed  <= n_zclosed;
            r_zoff     <= n_zoff;
            r_met      <= n_met;
            r_znamed   <= n_znamed;
            r_zentry   <= n_zentry;
        end
    end

    // zone text and arithmetic results carry no reset
    always_ff @(posedge i_clk) begin
        r_g   <= n_g;
        r_out <= n_out;
        for (int j = 0; j < ZONE_CHARS; j++) begin
            if (txt_we && cur_zlen == ZLW'(j)) begin
                r_ztxt[j] <= lc;
            end
        end
    end

    assign o_out_beat = r_out;

endmodule

// ===== rtl/email_date_to_epoch_parser.sv =====
// top level of the e-mail date parser: controller plus datapath
// depends on edte_pkg, edte_ctrl, edte_datapath
//
// One character beat is taken per cycle while scanning. The beat flagged
// end_of_string is followed by work in the datapath, one controller state
// per step (closing the last token, then the day, leap, hour, minute,
// second and zone steps of the epoch sum, each step of the sum one
// shift-add or small multiply); the result then sits in the output
// register until taken, while the next string is already accepted; only
// the zone step of that next string waits if the register still holds a
// result. The next string may start in the same cycle as the result beat.
module email_date_to_epoch_parser
    import edte_pkg::*;
#(
    parameter int MAX_LEN    = P_MAX_LEN,
    parameter int ZONE_CHARS = P_ZONE_CHARS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    t_dp_cmd cmd;

    edte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_beat.end_of_string),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    edte_datapath #(
        .MAX_LEN    (MAX_LEN),
        .ZONE_CHARS (ZONE_CHARS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_beat  (i_in_beat),
        .o_out_beat (o_out_beat)
    );

endmodule

// ===== dv/email_date_to_epoch_parser_tb.sv =====
// testbench for email_date_to_epoch_parser: random and directed date strings
// byte beats, checked against an in-bench parser model; depends on edte_pkg
module email_date_to_epoch_parser_tb;
    import edte_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  in_beat = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_beat o_out_beat;

    email_date_to_epoch_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_beat(in_beat),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_beat(o_out_beat)
    );

    always #4 i_clk = ~i_clk;

    t_in_beat  pending_beats[$];
    bit        hold_for_drain[$];
    t_out_beat expected_dates[$];
    byte       str_bytes[$];
    int        errors = 0;
    int        cycle_no = 0;
    int        stalled_cycles = 0;

    string zone_names[43] = '{"aat","adt","ast","bst","cat","cdt","cest","cet","cst","eat",
        "edt","eest","eet","egst","egt","est","gmt","gst","hkt","ict","idt","ist","jst",
        "kst","mdt","met","msd","msk","mst","nzdt","nzst","pdt","pst","sat","smt","sst",
        "utc","wat","west","wet","wgst","wgt","wst"};
    int zone_hours[43] = '{1,4,3,1,1,5,2,1,6,3,4,3,2,0,1,5,0,4,8,7,3,2,9,9,6,1,4,3,7,13,12,
        7,8,2,4,11,0,0,1,0,2,3,8};
    bit zone_west[43] = '{1,0,0,0,0,1,0,0,1,0,1,0,0,0,1,1,0,0,0,0,0,0,0,0,1,0,0,0,1,0,0,
        1,1,0,0,1,0,0,0,0,1,1,0};
    string month_names[12] = '{"jan","feb","mar","apr","may","jun","jul","aug","sep","oct",
        "nov","dec"};
    int month_days[12] = '{0,31,59,90,120,151,181,212,243,273,304,334};

    // parser model state
    int unsigned n_bytes;
    int          tok_no;
    bit          in_tok, comma_hit, bad, str_done;
    bit [31:0]   acc;
    t_num_phase  ph;
    bit          neg;
    bit [4:0]    mday;
    bit [3:0]    mon;
    bit [31:0]   yrs;
    bit [31:0]   hms[3];
    int          hms_idx, hms_cnt;
    byte         ztext[8];
    int          zlen;
    bit          zparen, zlead, zclosed, fresh;
    int          zoff;
    bit          met_seen, znamed;
    bit [5:0]    zidx;

    function automatic byte lc(byte c);
        return (c >= "A" && c <= "Z") ? byte'(c + 32) : c;
    endfunction

    function automatic bit dig(byte c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit zone_is(string s);
        if (zlen != s.len()) return 0;
        for (int i = 0; i < s.len(); i++) if (ztext[i] != s[i]) return 0;
        return 1;
    endfunction

    function automatic void clear_fields();
        tok_no = 0; in_tok = 0; bad = 0; acc = 0; ph = PH_START; neg = 0;
        mday = 0; mon = 0; yrs = 0; hms = '{0, 0, 0}; hms_idx = 0; hms_cnt = 0;
        ztext = '{default: 0}; zlen = 0; zparen = 0; zlead = 0; zclosed = 0; fresh = 0;
        zoff = 0; met_seen = 0; znamed = 0; zidx = 0;
    endfunction

    function automatic void clear_all();
        n_bytes = 0; comma_hit = 0; str_done = 0;
        clear_fields();
    endfunction

    function automatic void number_char(byte c);
        longint unsigned t;
        if (ph == PH_STOP) return;
        if (dig(c)) begin
            t = longint'(acc) * 10 + (c - "0");
            acc = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
            ph = PH_DIGITS;
        end else if (ph == PH_START && c >= 8'h0A && c <= 8'h0D) begin
        end else if (ph == PH_START && (c == "+" || c == "-")) begin
            neg = (c == "-"); ph = PH_SIGN;
        end else ph = PH_STOP;
    endfunction

    function automatic bit number_ok(output bit [31:0] v);
        v = acc;
        return ph == PH_DIGITS && !(neg && acc != 0) && acc <= 32'h7FFF_FFFF;
    endfunction

    function automatic void hms_store();
        if (hms_idx < 3) hms[hms_idx] = neg ? 32'd0 - acc : acc;
        hms_cnt++;
    endfunction

    function automatic void clock_char(byte c);
        if (ph == PH_STOP) return;
        if (dig(c)) begin
            acc = acc * 10 + (c - "0"); ph = PH_DIGITS;
        end else if (ph == PH_START && c >= 8'h0A && c <= 8'h0D) begin
        end else if (ph == PH_START && (c == "+" || c == "-")) begin
            neg = (c == "-"); ph = PH_SIGN;
        end else if (ph == PH_DIGITS && c == ":" && hms_idx < 2) begin
            hms_store(); hms_idx++; ph = PH_START; neg = 0; acc = 0;
        end else begin
            if (ph == PH_DIGITS) hms_store();
            ph = PH_STOP;
        end
    endfunction

    function automatic void zone_char(byte c, bit strip);
        if (zclosed) return;
        if (strip && fresh && c == "(") begin
            zparen = 1; zlead = 1; return;
        end
        if (zparen) begin
            if (c == ")") begin
                zclosed = 1; return;
            end
            if (zlead && (c == 8'h0D || c == 8'h0A)) return;
            zlead = 0;
        end
        if (zlen < 8) ztext[zlen] = lc(c);
        if (zlen <= 8) zlen++;
    endfunction

    function automatic void zone_close();
        int off;
        off = 0;
        if (zlen >= 1 && (ztext[0] == "+" || ztext[0] == "-")) begin
            if (zlen >= 5 && dig(ztext[1]) && dig(ztext[2]) && dig(ztext[3]) && dig(ztext[4]))
            begin
                off = ((ztext[1] - "0") * 10 + (ztext[2] - "0")) * 3600
                    + ((ztext[3] - "0") * 10 + (ztext[4] - "0")) * 60;
                if (ztext[0] == "+") off = -off;
            end
        end else begin
            for (int i = 0; i < 43; i++) begin
                if (zone_is(zone_names[i])) begin
                    off = zone_west[i] ? zone_hours[i] * 3600 : -zone_hours[i] * 3600;
                    znamed = 1; zidx = 6'(i);
                    break;
                end
            end
            if (!zparen && zone_is("met")) met_seen = 1;
        end
        zoff = off;
    endfunction

    function automatic void token_close();
        bit [31:0] v;
        case (tok_no)
            0: if (number_ok(v) && v <= 31) mday = v[4:0]; else bad = 1;
            1: begin
                bad = 1;
                if (zlen >= 3)
                    for (int i = 0; i < 12; i++)
                        if (ztext[0] == month_names[i][0] && ztext[1] == month_names[i][1]
                            && ztext[2] == month_names[i][2]) begin
                            mon = 4'(i); bad = 0; break;
                        end
            end
            2: if (number_ok(v)) begin
                if (v < 50) v += 100;
                else if (v >= 1900) v -= 1900;
                yrs = v;
            end else bad = 1;
            3: begin
                if (ph == PH_DIGITS) hms_store();
                if (hms_cnt < 2) bad = 1;
                else if (hms_cnt == 2) hms[2] = 0;
            end
            4: zone_close();
            5: if (met_seen && zone_is("dst")) zoff -= 3600;
            default: ;
        endcase
        if (tok_no < 7) tok_no++;
        in_tok = 0;
    endfunction

    function automatic void parse_char(byte c);
        if (c == "," && !comma_hit) begin
            comma_hit = 1; clear_fields(); return;
        end
        if (c == " " || c == 8'h09) begin
            if (in_tok) token_close();
            return;
        end
        if (!in_tok) begin
            if (tok_no == 0 && (c == 8'h0D || c == 8'h0A)) return;
            in_tok = 1; fresh = 1; acc = 0; ph = PH_START; neg = 0;
            hms_idx = 0; hms_cnt = 0; zlen = 0; zparen = 0; zlead = 0; zclosed = 0;
        end
        case (tok_no)
            0, 2: number_char(c);
            1, 5: zone_char(c, 0);
            3: clock_char(c);
            4: zone_char(c, 1);
            default: ;
        endcase
        fresh = 0;
    endfunction

    // one accepted beat; pushes the expected date when the string ends
    function automatic void predict_date(t_in_beat b);
        t_out_beat r;
        longint yr, g;
        if (!str_done && n_bytes < 127) begin
            n_bytes++;
            if (b.text_byte == 0) str_done = 1;
            else parse_char(b.text_byte);
        end
        if (!b.end_of_string) return;
        if (in_tok) token_close();
        r = '0;
        if (bad || tok_no < 4) begin
            r.parse_status = 1; r.epoch_seconds = -64'sd1;
        end else begin
            yr = longint'(yrs);
            g = month_days[mon % 12] + mday;
            if ((yr % 4) != 0 || mon < 2) g--;
            g += (yr - 70) * 365;
            g += (yr - 69) / 4;
            g = g * 24 + longint'(int'(hms[0]));
            g = g * 60 + longint'(int'(hms[1]));
            g = g * 60 + longint'(int'(hms[2]));
            g += zoff;
            r.epoch_seconds = g;
            r.zone_named = znamed;
            r.zone_entry = znamed ? zidx : 6'd0;
        end
        expected_dates.push_back(r);
        clear_all();
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
    endfunction

    function automatic void commit_string(bit hold);
        t_in_beat b;
        foreach (str_bytes[i]) begin
            b.text_byte = str_bytes[i];
            b.end_of_string = (i == str_bytes.size() - 1);
            pending_beats.push_back(b);
            hold_for_drain.push_back(hold && i == 0);
        end
        str_bytes.delete();
    endfunction

    function automatic string mixed_case(string s);
        string o;
        o = s;
        for (int i = 0; i < o.len(); i++)
            if ($urandom_range(0, 1) && o[i] >= "a" && o[i] <= "z") o[i] = o[i] - 32;
        return o;
    endfunction

    function automatic string gap();
        return $urandom_range(0, 3) == 0 ? " \t" : ($urandom_range(0, 4) == 0 ? "\t" : " ");
    endfunction

    function automatic void add_good_date(int pad);
        int k;
        if ($urandom_range(0, 1)) add_text($sformatf("%s, ", mixed_case("thu")));
        if ($urandom_range(0, 6) == 0) add_text("\r\n");
        add_text($urandom_range(0, 3) == 0 ? $sformatf("%02d", $urandom_range(0, 31))
                                           : $sformatf("%0d", $urandom_range(0, 31)));
        add_text(gap());
        add_text(mixed_case(month_names[$urandom_range(0, 11)]));
        if ($urandom_range(0, 5) == 0) add_text("uary");
        repeat (pad) add_text(" ");
        add_text(gap());
        case ($urandom_range(0, 3))
            0: add_text($sformatf("%02d", $urandom_range(0, 99)));
            1: add_text($sformatf("%0d", $urandom_range(1900, 2200)));
            2: add_text($sformatf("%0d", $urandom_range(50, 1899)));
            default: add_text($sformatf("%0d", $urandom_range(1970, 2099)));
        endcase
        add_text(gap());
        add_text($sformatf("%02d:%02d", $urandom_range(0, 23), $urandom_range(0, 59)));
        if ($urandom_range(0, 2)) add_text($sformatf(":%02d", $urandom_range(0, 60)));
        if ($urandom_range(0, 9) == 0) add_text(".5");
        if ($urandom_range(0, 7) == 0) return;
        add_text(gap());
        k = $urandom_range(0, 43);
        case ($urandom_range(0, 5))
            0, 1: add_text($sformatf("%s%02d%02d", $urandom_range(0, 1) ? "+" : "-",
                                     $urandom_range(0, 14), $urandom_range(0, 59)));
            2: add_text(mixed_case(k < 43 ? zone_names[k] : "xyz"));
            3: add_text($sformatf("(%s)", mixed_case(k < 43 ? zone_names[k] : "foo")));
            4: add_text({mixed_case("met"), gap(), mixed_case("dst")});
            default: add_text({mixed_case(zone_names[k % 43]), " (",
                               mixed_case(zone_names[k % 43]), ")"});
        endcase
    endfunction

    function automatic void add_noise();
        string cs;
        cs = "0123456789:+-() ,\t\r\njanMETdstFEBgmt";
        repeat ($urandom_range(1, 20))
            str_bytes.push_back($urandom_range(0, 3) == 0 ? byte'($urandom_range(1, 255))
                                                          : cs[$urandom_range(0, cs.len() - 1)]);
        if ($urandom_range(0, 9) == 0) str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'h00;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic     nv;
        t_in_beat nb;
        bit       idle;
        nv = in_valid;
        nb = in_beat;
        if (i_rst_n) begin
            idle = (cycle_no > 2000 && cycle_no < 4000) ? 1'b0 : ($urandom_range(0, 99) < 11);
            if (in_valid && o_in_ready) begin
                predict_date(in_beat);
                void'(pending_beats.pop_front());
                void'(hold_for_drain.pop_front());
                nv = 1'b0;
            end
            if (!nv && pending_beats.size() > 0 && !idle
                && !(hold_for_drain[0] && expected_dates.size() > 0)) begin
                nv = 1'b1;
                nb = pending_beats[0];
            end
            in_valid <= nv;
            in_beat  <= nb;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n) begin
            cycle_no <= cycle_no + 1;
            if (o_out_valid && out_ready) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t: unexpected beat %p", $time, o_out_beat);
                    errors++;
                end else begin
                    e = expected_dates.pop_front();
                    if (o_out_beat.parse_status !== e.parse_status)
                        $display("%0t: parse_status exp %0d got %0d", $time,
                                 e.parse_status, o_out_beat.parse_status);
                    if (o_out_beat.epoch_seconds !== e.epoch_seconds)
                        $display("%0t: epoch_seconds exp %0d got %0d", $time,
                                 e.epoch_seconds, o_out_beat.epoch_seconds);
                    if (o_out_beat.zone_named !== e.zone_named)
                        $display("%0t: zone_named exp %0d got %0d", $time,
                                 e.zone_named, o_out_beat.zone_named);
                    if (o_out_beat.zone_entry !== e.zone_entry)
                        $display("%0t: zone_entry exp %0d got %0d", $time,
                                 e.zone_entry, o_out_beat.zone_entry);
                    if (o_out_beat !== e) errors++;
                end
            end
            out_ready <= (cycle_no > 2000 && cycle_no < 4000) ? 1'b1
                                                              : ($urandom_range(0, 99) >= 11);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) stalled_cycles <= 0;
            else stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles > 2000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        string directed[$];
        clear_all();
        directed = '{"Thu, 01 Jan 1970 00:00:00 +0000", "31 dec 2099 23:59:59 -2359",
            "1 FEB 49 12:30 (PST)", "5 Mar 50 1:2:3 MET DST", "7 Apr 1899 10:00 (\r\nGMT)",
            "-0 May 0 0:0 nzdt", "32 jun 70 1:1 utc", "1 Jux 70 1:1", "1 jan 70",
            "+1 jan 2147483647 -1:-1:-1 xyz", "1 ja 70 1:1 gmt", "4294967296 jan 70 1:1 gmt",
            "\r\n1 jan 70 1:1 cest a b c d", "1 jan 70 1 gmt", "1 jan 70 12:00 +12",
            "x, y, 9 Oct 2000 4294967295:1:2 (met) dst", "1 jan 70 1:1 metdst",
            "2 aug 1999 10:10 met xyz", "a,\t\t3\tSEP\t\t2024\t9:9:9\twgst"};
        foreach (directed[i]) begin
            add_text(directed[i]);
            commit_string(0);
        end
        str_bytes.push_back(8'h00); commit_string(0);
        str_bytes.push_back(8'hFF); str_bytes.push_back(8'h7F); commit_string(0);
        for (int n = 0; pending_beats.size() < 1040; n++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: add_noise();
                3, 4: begin
                    add_good_date(0);
                    str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
                        byte'($urandom_range(1, 255));
                end
                default: add_good_date(n % 30 == 7 ? $urandom_range(100, 130) : 0);
            endcase
            commit_string(n % 13 == 5);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_beats.size() > 0 || expected_dates.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0 && expected_dates.size() == 0 && !o_out_valid) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/edte_pkg.sv
rtl/edte_ctrl.sv
rtl/edte_datapath.sv
rtl/email_date_to_epoch_parser.sv
dv/email_date_to_epoch_parser_tb.sv
